[src/p12sb_pkg.sv]
// ----------------------------------------------------------------------------
// p12sb_pkg
// Shared types and constants for the packed 12-bit spectrum scaler/binner.
// ----------------------------------------------------------------------------
package p12sb_pkg;

   localparam int MaxChannels = 4096;
   localparam int MaxBin      = 64;
   localparam int QueueDepth  = 2;
   // Divider: quotient bits resolved per cycle and number of cycles
   localparam int DivBits     = 8;
   localparam int DivSteps    = 7;
   localparam int DivWidth    = DivBits * DivSteps;

   // Configuration register indexes
   localparam logic [2:0] RegScale      = 3'd0;
   localparam logic [2:0] RegOffset     = 3'd1;
   localparam logic [2:0] RegArrayScale = 3'd2;
   localparam logic [2:0] RegBinWidth   = 3'd3;
   localparam logic [2:0] RegFirstChan  = 3'd4;
   localparam logic [2:0] RegOutChans   = 3'd5;

   localparam logic [47:0] ValPosMax = 48'h7FFF_FFFF_FFFF;
   localparam logic [48:0] ValNegMag = 49'h0_8000_0000_0000;

   // One closed bin, handed from front to back
   typedef struct packed {
      logic [17:0] sum;
      logic [6:0]  fill;
      logic [11:0] channel;
      logic        last;
   } job_type;

   typedef struct packed {
      logic signed [31:0] scale;
      logic signed [31:0] offset;
      logic signed [31:0] array_scale;
      logic [6:0]         bin_width;
      logic [11:0]        first_channel;
      logic [12:0]        out_channels;
   } cfg_type;

endpackage

[src/packed12_spectrum_scale_bin.sv]
// ----------------------------------------------------------------------------
// packed12_spectrum_scale_bin
// Unpacks 12-bit spectral samples from a byte stream, bins and scales them.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while its two-entry job queue has room;
// every three bytes give two samples. Each closed bin goes through the
// scaling back end one job at a time (an idle slot that pops the job, a
// multiply stage, a sum stage, the steps of a radix-256 divider for the bin
// mean, a product stage and a rounding stage that waits while the output
// is stalled). A result waits in the output register while the back end
// starts on the next job. Configuration writes take effect at once and are
// meant for idle periods.
// ----------------------------------------------------------------------------
module packed12_spectrum_scale_bin import p12sb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_record_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [47:0] rsp_value,
   output logic [11:0] rsp_channel,
   output logic        rsp_last
);

   cfg_type cfg_ff;
   logic    push, q_full, q_not_empty, pop;
   job_type push_job, head_job;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale         <= 32'sd65536;
         cfg_ff.offset        <= 32'sd0;
         cfg_ff.array_scale   <= 32'sd65536;
         cfg_ff.bin_width     <= 7'd1;
         cfg_ff.first_channel <= 12'd0;
         cfg_ff.out_channels  <= 13'(MaxChannels);
      end else if (csr_we) begin
         case (csr_index)
            RegScale:      cfg_ff.scale         <= csr_wdata;
            RegOffset:     cfg_ff.offset        <= csr_wdata;
            RegArrayScale: cfg_ff.array_scale   <= csr_wdata;
            RegBinWidth:   cfg_ff.bin_width     <= csr_wdata[6:0];
            RegFirstChan:  cfg_ff.first_channel <= csr_wdata[11:0];
            RegOutChans:   cfg_ff.out_channels  <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   p12sb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_record_start (req_record_start),
      .push             (push),
      .push_job         (push_job),
      .q_full           (q_full)
   );

   p12sb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   p12sb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .head_job    (head_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_value   (rsp_value),
      .rsp_channel (rsp_channel),
      .rsp_last    (rsp_last)
   );

endmodule

[src/p12sb_queue.sv]
// ----------------------------------------------------------------------------
// p12sb_queue
// Two-entry job queue between the byte front end and the scaling back end.
// ----------------------------------------------------------------------------
module p12sb_queue import p12sb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head_job
);

   job_type    mem_ff [QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'(QueueDepth));
   assign not_empty = (count_ff != 2'd0);
   assign head_job  = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QueueDepth)) else $error("queue count out of range");

endmodule

[src/p12sb_front.sv]
// ----------------------------------------------------------------------------
// p12sb_front
// Byte front end: unpacks 12-bit samples, counts channels, fills bins and
// pushes each closed bin as a job.
// ----------------------------------------------------------------------------
module p12sb_front import p12sb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_record_start,
   output logic       push,
   output job_type    push_job,
   input  logic       q_full
);

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic [12:0] raw_cnt_ff, raw_cnt_in;
   logic [17:0] sum_ff, sum_in;
   logic [6:0]  fill_ff, fill_in;
   logic [12:0] out_cnt_ff, out_cnt_in;

   logic        accept;
   logic [1:0]  b_phase;
   logic [7:0]  b_held;
   logic [12:0] b_raw, b_out;
   logic [17:0] b_sum, sum_add;
   logic [6:0]  b_fill, fill_add, n_eff;
   logic [12:0] limit;
   logic [11:0] start;
   logic        have_sample;
   logic [11:0] sample;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Clamp bin width and output count
   always_comb begin
      n_eff = cfg.bin_width;
      if (n_eff == 7'd0) begin
         n_eff = 7'd1;
      end else if (n_eff > 7'(MaxBin)) begin
         n_eff = 7'(MaxBin);
      end
      limit = (cfg.out_channels > 13'(MaxChannels)) ? 13'(MaxChannels) : cfg.out_channels;
      start = (n_eff == 7'd1) ? 12'd0 : cfg.first_channel;
   end

   // Unpack, classify and bin one byte
   always_comb begin
      b_phase = req_record_start ? 2'd0  : phase_ff;
      b_held  = req_record_start ? 8'd0  : held_ff;
      b_raw   = req_record_start ? 13'd0 : raw_cnt_ff;
      b_sum   = req_record_start ? 18'd0 : sum_ff;
      b_fill  = req_record_start ? 7'd0  : fill_ff;
      b_out   = req_record_start ? 13'd0 : out_cnt_ff;

      have_sample = 1'b0;
      sample      = 12'd0;
      phase_in    = b_phase;
      held_in     = b_held;
      case (b_phase)
         2'd0: begin
            held_in  = req_data_byte;
            phase_in = 2'd1;
         end
         2'd1: begin
            sample      = {b_held, req_data_byte[7:4]};
            held_in     = {4'd0, req_data_byte[3:0]};
            phase_in    = 2'd2;
            have_sample = 1'b1;
         end
         default: begin
            sample      = {b_held[3:0], req_data_byte};
            held_in     = 8'd0;
            phase_in    = 2'd0;
            have_sample = 1'b1;
         end
      endcase

      raw_cnt_in = b_raw;
      sum_in     = b_sum;
      fill_in    = b_fill;
      out_cnt_in = b_out;
      sum_add    = b_sum + {6'd0, sample};
      fill_add   = b_fill + 7'd1;
      push       = 1'b0;
      push_job   = '{sum: sum_add, fill: fill_add, channel: b_out[11:0],
                     last: (b_out + 13'd1 == limit)};
      if (have_sample && b_raw < 13'(MaxChannels)) begin
         raw_cnt_in = b_raw + 13'd1;
         if (b_out < limit && b_raw >= {1'b0, start}) begin
            if (fill_add >= n_eff) begin
               push       = accept;
               out_cnt_in = b_out + 13'd1;
               sum_in     = 18'd0;
               fill_in    = 7'd0;
            end else begin
               sum_in  = sum_add;
               fill_in = fill_add;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 2'd0;
         held_ff    <= 8'd0;
         raw_cnt_ff <= 13'd0;
         sum_ff     <= 18'd0;
         fill_ff    <= 7'd0;
         out_cnt_ff <= 13'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         raw_cnt_ff <= raw_cnt_in;
         sum_ff     <= sum_in;
         fill_ff    <= fill_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

endmodule

[src/p12sb_back.sv]
// ----------------------------------------------------------------------------
// p12sb_back
// Scaling back end: forms the bin total, averages it with a radix-256
// divider, applies the array multiplier, rounds and saturates.
// ----------------------------------------------------------------------------
module p12sb_back import p12sb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         q_not_empty,
   input  job_type      head_job,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [47:0]  rsp_value,
   output logic [11:0]  rsp_channel,
   output logic         rsp_last
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_SUM  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_PROD = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   job_type             job_ff;
   logic signed [50:0]  ps_ff;
   logic signed [39:0]  po_ff;
   logic                tneg_ff;
   logic [DivWidth-1:0] div_ff, div_in;
   logic [6:0]          rem_ff, rem_in;
   logic [2:0]          step_ff;
   logic [61:0]         hi_ff;
   logic [53:0]         lo_ff;
   logic                rsp_valid_ff;
   logic [47:0]         rsp_value_ff;
   logic [11:0]         rsp_channel_ff;
   logic                rsp_last_ff;

   logic signed [51:0]  t_sum;
   logic [51:0]         t_mag;
   logic [31:0]         a_mag;
   logic [51:0]         quo;
   logic [63:0]         round_sum;
   logic [48:0]         r_mag;
   logic [47:0]         value_in;
   logic [7:0]          rem_try;
   logic [DivBits-1:0]  q_bits;
   logic                out_free;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign pop         = (state_ff == ST_IDLE) && q_not_empty;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_last    = rsp_last_ff;

   assign t_sum = 52'(ps_ff) + 52'(po_ff);
   assign t_mag = t_sum[51] ? 52'(-t_sum) : 52'(t_sum);
   assign a_mag = cfg.array_scale[31] ? 32'(-cfg.array_scale) : 32'(cfg.array_scale);
   assign quo   = div_ff[51:0];

   // Resolve eight quotient bits per cycle
   always_comb begin
      rem_in = rem_ff;
      q_bits = '0;
      for (int j = 0; j < DivBits; j++) begin
         rem_try = {rem_in, div_ff[DivWidth-1-j]};
         if (rem_try >= {1'b0, job_ff.fill}) begin
            rem_try              = rem_try - {1'b0, job_ff.fill};
            q_bits[DivBits-1-j] = 1'b1;
         end
         rem_in = rem_try[6:0];
      end
      div_in = {div_ff[DivWidth-DivBits-1:0], q_bits};
   end

   // Round to Q31.16 and saturate
   always_comb begin
      round_sum = {hi_ff[41:0], 22'd0} + {10'd0, lo_ff} + 64'h8000;
      if (hi_ff >= 62'h200_0000_0000) begin
         r_mag = ValNegMag;
      end else begin
         r_mag = round_sum[63:15] >> 1;
      end
      if (tneg_ff != cfg.array_scale[31]) begin
         if (r_mag > ValNegMag) begin
            r_mag = ValNegMag;
         end
         value_in = 48'(-r_mag);
      end else begin
         value_in = (r_mag > {1'b0, ValPosMax}) ? ValPosMax : r_mag[47:0];
      end
   end

   // Sequence one job through the datapath
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (q_not_empty) state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_DIV;
         ST_DIV:  if (step_ff == 3'(DivSteps - 1)) state_in = ST_PROD;
         ST_PROD: state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
      end
      if (state_ff == ST_MUL) begin
         ps_ff <= $signed({1'b0, job_ff.sum}) * cfg.scale;
         po_ff <= $signed({1'b0, job_ff.fill}) * cfg.offset;
      end
      if (state_ff == ST_SUM) begin
         tneg_ff <= t_sum[51];
         div_ff  <= DivWidth'(t_mag + {46'd0, job_ff.fill[6:1]});
         rem_ff  <= 7'd0;
         step_ff <= 3'd0;
      end
      if (state_ff == ST_DIV) begin
         div_ff  <= div_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + 3'd1;
      end
      if (state_ff == ST_PROD) begin
         hi_ff <= 62'(quo[51:22]) * 62'(a_mag);
         lo_ff <= 54'(quo[21:0]) * 54'(a_mag);
      end
      if (state_ff == ST_FIN && out_free) begin
         rsp_value_ff   <= value_in;
         rsp_channel_ff <= job_ff.channel;
         rsp_last_ff    <= job_ff.last;
      end
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == ST_MUL) else $error("pop did not start a job");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> step_ff < 3'(DivSteps)) else $error("divider overran");
   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free) |=> rsp_valid_ff) else $error("result lost");

endmodule
